// ===== hw/rtl/wpsp_pkg.sv =====
// shared types, codes and helpers for the wav pcm stream parser
package wpsp_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h52494646;
	localparam logic [31:0] TAG_WAVE = 32'h57415645;
	localparam logic [31:0] TAG_FMT  = 32'h666D7420;
	localparam logic [31:0] TAG_DATA = 32'h64617461;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_BAD_TAGS  = 3'd2;
	localparam logic [2:0] ST_FMT_SMALL = 3'd3;
	localparam logic [2:0] ST_NO_DATA   = 3'd4;
	localparam logic [2:0] ST_NOT_PCM   = 3'd5;
	localparam logic [2:0] ST_ZERO_FRM  = 3'd6;

	localparam logic [15:0] FMT_PCM = 16'd1;

	// header length, minimum file length, minimum fmt body
	localparam int HDR_BYTES = 12;
	localparam int MIN_FILE  = 44;
	localparam int FMT_MIN   = 16;

	localparam int POS_W = 6;
	localparam int OFF_W = 5;
	localparam int FRM_W = 29;

	localparam int FIFO_DEPTH = 3;

	typedef struct packed {
		logic        is_status;
		logic [31:0] sample;
		logic [2:0]  status;
		logic [31:0] rate;
		logic [15:0] channel_count;
		logic [15:0] sample_bits;
		logic        done_res;
	} res_t;

	function automatic logic [31:0] set_lane32(input logic [31:0] v, input logic [1:0] lane,
		input logic [7:0] b);
		logic [31:0] r;
		r = v;
		case (lane)
			2'd0: r[7:0] = b;
			2'd1: r[15:8] = b;
			2'd2: r[23:16] = b;
			default: r[31:24] = b;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] inc3(input logic [1:0] p);
		return (p == 2'(FIFO_DEPTH - 1)) ? 2'd0 : p + 2'd1;
	endfunction

endpackage

// ===== hw/rtl/wav_pcm_stream_parser_core.sv =====
// wav pcm stream parser: byte-wide riff/wave walker with sample and status output queue
//
//  channel | direction | handshake            | payload
//  in      | to block  | in_valid / in_stall  | file_byte, final_byte
//  out     | from block| out_valid / out_stall| is_status, sample, status, rate,
//          |           |                      | channel_count, sample_bits, done_res
//
//  one word is taken per cycle while in_stall is low and parsed in the cycle it is accepted
//  its results enter a three-entry queue and are offered from the next cycle
//  a final word may add two entries at once, a sample and then the status
//  in_stall is high while the queue holds two or more entries
//  arst_n clears all parser state and empties the queue; a final word clears the parser
//  out_stall only holds the queue head; parsing continues until two entries wait
module wav_pcm_stream_parser_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         file_byte,
	input  logic               final_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               is_status,
	output logic signed [31:0] sample,
	output logic [2:0]         status,
	output logic [31:0]        rate,
	output logic [15:0]        channel_count,
	output logic [15:0]        sample_bits,
	output logic               done_res
);

	localparam logic [1:0] PH_HDR  = 2'd0;
	localparam logic [1:0] PH_BODY = 2'd1;
	localparam logic [1:0] PH_PAD  = 2'd2;

	logic [wpsp_pkg::POS_W-1:0] pos_q, pos_n;
	logic                       tag_err_q, tag_err_n;
	logic [31:0]                tag_q, tag_n;
	logic [31:0]                rem_q, rem_n;
	logic [1:0]                 phase_q, phase_n;
	logic [2:0]                 hdr_idx_q, hdr_idx_n;
	logic [wpsp_pkg::OFF_W-1:0] off_q, off_n;
	logic                       pad_q, pad_n;
	logic [15:0]                fcode_q, fcode_n;
	logic [15:0]                fch_q, fch_n;
	logic [31:0]                frate_q, frate_n;
	logic [15:0]                fbits_q, fbits_n;
	logic                       fseen_q, fseen_n;
	logic                       fsmall_q, fsmall_n;
	logic                       dseen_q, dseen_n;
	logic                       ddone_q, ddone_n;
	logic [wpsp_pkg::FRM_W-1:0] fbi_q, fbi_n;
	logic [31:0]                asm_q, asm_n;
	logic [wpsp_pkg::FRM_W-1:0] frame_sz_q;

	wpsp_pkg::res_t fifo_q [wpsp_pkg::FIFO_DEPTH];
	logic [1:0]     rd_q, wr_q, wr1, wr_n;
	logic [1:0]     cnt_q, cnt_n;
	logic [1:0]     n_push;
	wpsp_pkg::res_t r0, r1, smp_res, st_res;

	logic                       in_acc, out_pop;
	logic                       smp_fire;
	logic [wpsp_pkg::FRM_W:0]   fbi_inc;
	logic [31:0]                asm_w;
	logic [31:0]                smp_val;
	logic                       frame_zero_q, frame_zero_n;
	logic                       stream_ok;
	logic [2:0]                 code;

	assign in_acc  = in_valid && !in_stall;
	assign in_stall = cnt_q > 2'd1;
	assign out_valid = cnt_q != 2'd0;
	assign out_pop = out_valid && !out_stall;

	assign frame_zero_q = (fch_q == 16'd0) || (fbits_q[15:3] == 13'd0);
	assign stream_ok = !tag_err_q && fseen_q && !fsmall_q && (fcode_q == wpsp_pkg::FMT_PCM)
		&& !frame_zero_q;
	assign fbi_inc = {1'b0, fbi_q} + 1'b1;
	assign asm_w = (fbi_q < wpsp_pkg::FRM_W'(4)) ? wpsp_pkg::set_lane32(asm_q, fbi_q[1:0],
		file_byte) : asm_q;

	always_comb begin
		case (fbits_q)
			16'd16: smp_val = {asm_w[15:0], 16'd0};
			16'd24: smp_val = {asm_w[23:0], 8'd0};
			16'd32: smp_val = asm_w;
			default: smp_val = 32'd0;
		endcase
	end

	// parser next state
	always_comb begin
		pos_n     = pos_q;
		tag_err_n = tag_err_q;
		tag_n     = tag_q;
		rem_n     = rem_q;
		phase_n   = phase_q;
		hdr_idx_n = hdr_idx_q;
		off_n     = off_q;
		pad_n     = pad_q;
		fcode_n   = fcode_q;
		fch_n     = fch_q;
		frate_n   = frate_q;
		fbits_n   = fbits_q;
		fseen_n   = fseen_q;
		fsmall_n  = fsmall_q;
		dseen_n   = dseen_q;
		ddone_n   = ddone_q;
		fbi_n     = fbi_q;
		asm_n     = asm_q;
		smp_fire  = 1'b0;

		if (pos_q < wpsp_pkg::POS_W'(wpsp_pkg::HDR_BYTES)) begin
			if (pos_q < wpsp_pkg::POS_W'(4)
				&& file_byte != wpsp_pkg::TAG_RIFF[8*(3-pos_q[1:0]) +: 8])
				tag_err_n = 1'b1;
			if (pos_q >= wpsp_pkg::POS_W'(8)
				&& file_byte != wpsp_pkg::TAG_WAVE[8*(3-pos_q[1:0]) +: 8])
				tag_err_n = 1'b1;
		end else begin
			unique case (phase_q)
				PH_HDR: begin
					if (!hdr_idx_q[2])
						tag_n = {tag_q[23:0], file_byte};
					else
						rem_n = wpsp_pkg::set_lane32(rem_q, hdr_idx_q[1:0], file_byte);
					hdr_idx_n = hdr_idx_q + 3'd1;
					if (hdr_idx_q == 3'd7) begin
						off_n = '0;
						pad_n = rem_n[0];
						if (tag_q == wpsp_pkg::TAG_FMT) begin
							if (dseen_q) begin
								tag_n = '0;
							end else begin
								fseen_n = 1'b1;
								if (rem_n < 32'(wpsp_pkg::FMT_MIN))
									fsmall_n = 1'b1;
							end
						end else if (tag_q == wpsp_pkg::TAG_DATA) begin
							if (dseen_q) begin
								tag_n = '0;
							end else begin
								dseen_n = 1'b1;
								fbi_n   = '0;
								asm_n   = '0;
							end
						end
						if (rem_n == 32'd0) begin
							// empty chunk: an accepted data chunk ends at once
							if (tag_n == wpsp_pkg::TAG_DATA && dseen_n)
								ddone_n = 1'b1;
							phase_n = PH_HDR;
						end else begin
							phase_n = PH_BODY;
						end
					end
				end
				PH_BODY: begin
					if (tag_q == wpsp_pkg::TAG_FMT && !fsmall_q
						&& off_q < wpsp_pkg::OFF_W'(wpsp_pkg::FMT_MIN)) begin
						if (off_q < wpsp_pkg::OFF_W'(2))
							fcode_n = 16'(wpsp_pkg::set_lane32({16'd0, fcode_q}, off_q[1:0],
								file_byte));
						else if (off_q < wpsp_pkg::OFF_W'(4))
							fch_n = 16'(wpsp_pkg::set_lane32({16'd0, fch_q}, off_q[1:0] - 2'd2,
								file_byte));
						else if (off_q < wpsp_pkg::OFF_W'(8))
							frate_n = wpsp_pkg::set_lane32(frate_q, off_q[1:0], file_byte);
						else if (off_q >= wpsp_pkg::OFF_W'(14))
							fbits_n = 16'(wpsp_pkg::set_lane32({16'd0, fbits_q},
								off_q[1:0] - 2'd2, file_byte));
					end else if (tag_q == wpsp_pkg::TAG_DATA && dseen_q && !ddone_q
						&& stream_ok) begin
						if (fbi_inc >= {1'b0, frame_sz_q}) begin
							smp_fire = 1'b1;
							fbi_n    = '0;
							asm_n    = '0;
						end else begin
							fbi_n = fbi_inc[wpsp_pkg::FRM_W-1:0];
							asm_n = asm_w;
						end
					end
					if (off_q < wpsp_pkg::OFF_W'(wpsp_pkg::FMT_MIN))
						off_n = off_q + 1'b1;
					rem_n = rem_q - 32'd1;
					if (rem_n == 32'd0) begin
						if (tag_q == wpsp_pkg::TAG_DATA && dseen_q)
							ddone_n = 1'b1;
						phase_n = pad_q ? PH_PAD : PH_HDR;
					end
				end
				PH_PAD: phase_n = PH_HDR;
				default: phase_n = PH_HDR;
			endcase
		end

		if (pos_q != wpsp_pkg::POS_W'(wpsp_pkg::MIN_FILE))
			pos_n = pos_q + 1'b1;
	end

	assign frame_zero_n = (fch_n == 16'd0) || (fbits_n[15:3] == 13'd0);

	always_comb begin
		if (pos_n < wpsp_pkg::POS_W'(wpsp_pkg::MIN_FILE))
			code = wpsp_pkg::ST_SHORT;
		else if (tag_err_n)
			code = wpsp_pkg::ST_BAD_TAGS;
		else if (fsmall_n)
			code = wpsp_pkg::ST_FMT_SMALL;
		else if (!dseen_n)
			code = wpsp_pkg::ST_NO_DATA;
		else if (fcode_n != wpsp_pkg::FMT_PCM)
			code = wpsp_pkg::ST_NOT_PCM;
		else if (frame_zero_n)
			code = wpsp_pkg::ST_ZERO_FRM;
		else
			code = wpsp_pkg::ST_OK;
	end

	always_comb begin
		smp_res = '0;
		smp_res.sample = smp_val;
		st_res = '0;
		st_res.is_status     = 1'b1;
		st_res.status        = code;
		st_res.rate          = frate_n;
		st_res.channel_count = fch_n;
		st_res.sample_bits   = fbits_n;
		st_res.done_res      = 1'b1;

		r0 = smp_fire ? smp_res : st_res;
		r1 = st_res;
		if (!in_acc)
			n_push = 2'd0;
		else
			n_push = 2'(smp_fire) + 2'(final_byte);
	end

	assign wr1 = wpsp_pkg::inc3(wr_q);
	assign wr_n = (n_push == 2'd0) ? wr_q : (n_push == 2'd1) ? wr1 : wpsp_pkg::inc3(wr1);
	assign cnt_n = cnt_q - 2'(out_pop) + n_push;

	// result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (out_pop)
				rd_q <= wpsp_pkg::inc3(rd_q);
			wr_q  <= wr_n;
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < wpsp_pkg::FIFO_DEPTH; i++) begin
			if (n_push != 2'd0 && wr_q == 2'(i))
				fifo_q[i] <= r0;
			else if (n_push == 2'd2 && wr1 == 2'(i))
				fifo_q[i] <= r1;
		end
	end

	assign is_status     = fifo_q[rd_q].is_status;
	assign sample        = fifo_q[rd_q].sample;
	assign status        = fifo_q[rd_q].status;
	assign rate          = fifo_q[rd_q].rate;
	assign channel_count = fifo_q[rd_q].channel_count;
	assign sample_bits   = fifo_q[rd_q].sample_bits;
	assign done_res      = fifo_q[rd_q].done_res;

	// parser state; a final word returns everything but the frame size to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			tag_err_q  <= 1'b0;
			tag_q      <= '0;
			rem_q      <= '0;
			phase_q    <= PH_HDR;
			hdr_idx_q  <= '0;
			off_q      <= '0;
			pad_q      <= 1'b0;
			fcode_q    <= '0;
			fch_q      <= '0;
			frate_q    <= '0;
			fbits_q    <= '0;
			fseen_q    <= 1'b0;
			fsmall_q   <= 1'b0;
			dseen_q    <= 1'b0;
			ddone_q    <= 1'b0;
			fbi_q      <= '0;
			asm_q      <= '0;
			frame_sz_q <= '0;
		end else begin
			// frame size is registered from the fmt fields; data bodies start later
			frame_sz_q <= wpsp_pkg::FRM_W'(fch_q) * wpsp_pkg::FRM_W'(fbits_q[15:3]);
			if (in_acc) begin
				if (final_byte) begin
					pos_q     <= '0;
					tag_err_q <= 1'b0;
					tag_q     <= '0;
					rem_q     <= '0;
					phase_q   <= PH_HDR;
					hdr_idx_q <= '0;
					off_q     <= '0;
					pad_q     <= 1'b0;
					fcode_q   <= '0;
					fch_q     <= '0;
					frate_q   <= '0;
					fbits_q   <= '0;
					fseen_q   <= 1'b0;
					fsmall_q  <= 1'b0;
					dseen_q   <= 1'b0;
					ddone_q   <= 1'b0;
					fbi_q     <= '0;
					asm_q     <= '0;
				end else begin
					pos_q     <= pos_n;
					tag_err_q <= tag_err_n;
					tag_q     <= tag_n;
					rem_q     <= rem_n;
					phase_q   <= phase_n;
					hdr_idx_q <= hdr_idx_n;
					off_q     <= off_n;
					pad_q     <= pad_n;
					fcode_q   <= fcode_n;
					fch_q     <= fch_n;
					frate_q   <= frate_n;
					fbits_q   <= fbits_n;
					fseen_q   <= fseen_n;
					fsmall_q  <= fsmall_n;
					dseen_q   <= dseen_n;
					ddone_q   <= ddone_n;
					fbi_q     <= fbi_n;
					asm_q     <= asm_n;
				end
			end
		end
	end

	a_final_queues_status: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && final_byte |=> cnt_q != 2'd0)
		else $error("final word left no status in queue");

	a_done_needs_seen: assert property (@(posedge clk) disable iff (!arst_n)
		ddone_q |-> dseen_q)
		else $error("data chunk done without being seen");

	a_body_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> rem_q != 32'd0)
		else $error("chunk body with nothing remaining");

	a_frame_index: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY && tag_q == wpsp_pkg::TAG_DATA && frame_sz_q != '0
		|-> fbi_q < frame_sz_q)
		else $error("frame byte index out of range");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(wpsp_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

endmodule

// ===== test/tb_top.sv =====
// testbench for the wav pcm stream parser: byte-level file stimulus, local parser and result check
module tb_top;

	localparam logic [31:0] TAG_LIST = 32'h4C495354;
	localparam int QUIET_LIMIT = 3000;
	localparam int RANDOM_WORDS = 60;

	typedef enum logic [1:0] {WALK_HDR, WALK_BODY, WALK_PAD} walk_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         file_byte;
	logic               final_byte;
	logic               out_valid;
	logic               out_stall;
	logic               is_status;
	logic signed [31:0] sample;
	logic [2:0]         status;
	logic [31:0]        rate;
	logic [15:0]        channel_count;
	logic [15:0]        sample_bits;
	logic               done_res;

	// parser state
	logic [31:0] pos_cnt, cur_tag, bytes_left, frame_idx, asm_word, fmt_rate_q;
	logic [15:0] fmt_code_q, fmt_ch_q, fmt_bits_q;
	logic        bad_tag, pad_q, fmt_seen_q, fmt_small_q, data_seen_q, data_done_q;
	walk_t       walk;
	int          hdr_cnt, body_off;

	wpsp_pkg::res_t pending_out[$];
	logic [7:0]     file_buf[$];

	bit tx_idle, rx_idle;
	int rx_hold_req;
	int quiet_cycles;
	int bad_cnt, files_sent, words_sent, samples_checked, statuses_checked;

	wav_pcm_stream_parser_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.file_byte     (file_byte),
		.final_byte    (final_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.is_status     (is_status),
		.sample        (sample),
		.status        (status),
		.rate          (rate),
		.channel_count (channel_count),
		.sample_bits   (sample_bits),
		.done_res      (done_res)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] with_byte(input logic [31:0] v, input int idx,
		input logic [7:0] b);
		logic [31:0] r;
		r = v;
		r[8 * (idx % 4) +: 8] = b;
		return r;
	endfunction

	function automatic void expect_word(input wpsp_pkg::res_t r);
		pending_out.insert(pending_out.size(), r);
	endfunction

	function automatic void append_byte(input logic [7:0] b);
		file_buf.insert(file_buf.size(), b);
	endfunction

	function automatic void clear_parser();
		pos_cnt = '0; cur_tag = '0; bytes_left = '0; frame_idx = '0; asm_word = '0;
		fmt_rate_q = '0; fmt_code_q = '0; fmt_ch_q = '0; fmt_bits_q = '0;
		bad_tag = 1'b0; pad_q = 1'b0; fmt_seen_q = 1'b0; fmt_small_q = 1'b0;
		data_seen_q = 1'b0; data_done_q = 1'b0;
		walk = WALK_HDR; hdr_cnt = 0; body_off = 0;
	endfunction

	function automatic logic [31:0] frame_bytes();
		return 32'(fmt_ch_q) * 32'(fmt_bits_q >> 3);
	endfunction

	function automatic logic samples_enabled();
		return !bad_tag && fmt_seen_q && !fmt_small_q && fmt_code_q == wpsp_pkg::FMT_PCM &&
			frame_bytes() != 0;
	endfunction

	function automatic void close_chunk();
		if (cur_tag == wpsp_pkg::TAG_DATA && data_seen_q)
			data_done_q = 1'b1;
		walk = pad_q ? WALK_PAD : WALK_HDR;
	endfunction

	function automatic void parse_byte(input logic [7:0] b, input logic fin);
		wpsp_pkg::res_t r;
		logic [31:0] smp;
		logic [2:0] code;
		if (pos_cnt < wpsp_pkg::HDR_BYTES) begin
			if (pos_cnt < 4 && b != 8'(wpsp_pkg::TAG_RIFF >> (24 - 8 * pos_cnt)))
				bad_tag = 1'b1;
			if (pos_cnt >= 8 && b != 8'(wpsp_pkg::TAG_WAVE >> (88 - 8 * pos_cnt)))
				bad_tag = 1'b1;
		end else if (walk == WALK_HDR) begin
			if (hdr_cnt < 4) begin
				cur_tag = {cur_tag[23:0], b};
				if (hdr_cnt == 0)
					bytes_left = '0;
			end else
				bytes_left = with_byte(bytes_left, hdr_cnt - 4, b);
			hdr_cnt++;
			if (hdr_cnt >= 8) begin
				hdr_cnt = 0;
				body_off = 0;
				pad_q = bytes_left[0];
				if (cur_tag == wpsp_pkg::TAG_FMT) begin
					if (data_seen_q)
						cur_tag = '0;
					else begin
						fmt_seen_q = 1'b1;
						if (bytes_left < wpsp_pkg::FMT_MIN)
							fmt_small_q = 1'b1;
					end
				end else if (cur_tag == wpsp_pkg::TAG_DATA) begin
					if (data_seen_q)
						cur_tag = '0;
					else begin
						data_seen_q = 1'b1;
						frame_idx = '0;
						asm_word = '0;
					end
				end
				if (bytes_left == 0)
					close_chunk();
				else
					walk = WALK_BODY;
			end
		end else if (walk == WALK_BODY) begin
			if (cur_tag == wpsp_pkg::TAG_FMT && !fmt_small_q && body_off < wpsp_pkg::FMT_MIN)
				begin
				if (body_off < 2)
					fmt_code_q = 16'(with_byte(32'(fmt_code_q), body_off, b));
				else if (body_off < 4)
					fmt_ch_q = 16'(with_byte(32'(fmt_ch_q), body_off - 2, b));
				else if (body_off < 8)
					fmt_rate_q = with_byte(fmt_rate_q, body_off - 4, b);
				else if (body_off >= 14)
					fmt_bits_q = 16'(with_byte(32'(fmt_bits_q), body_off - 14, b));
			end else if (cur_tag == wpsp_pkg::TAG_DATA && data_seen_q && !data_done_q &&
				samples_enabled()) begin
				if (frame_idx < 4)
					asm_word = with_byte(asm_word, frame_idx, b);
				frame_idx++;
				if (frame_idx >= frame_bytes()) begin
					case (fmt_bits_q)
						16'd16: smp = {asm_word[15:0], 16'd0};
						16'd24: smp = {asm_word[23:0], 8'd0};
						16'd32: smp = asm_word;
						default: smp = '0;
					endcase
					r = '0;
					r.sample = smp;
					expect_word(r);
					frame_idx = '0;
					asm_word = '0;
				end
			end
			if (body_off < wpsp_pkg::FMT_MIN)
				body_off++;
			bytes_left--;
			if (bytes_left == 0)
				close_chunk();
		end else
			walk = WALK_HDR;

		if (pos_cnt != '1)
			pos_cnt++;

		if (fin) begin
			if (pos_cnt < wpsp_pkg::MIN_FILE)
				code = wpsp_pkg::ST_SHORT;
			else if (bad_tag)
				code = wpsp_pkg::ST_BAD_TAGS;
			else if (fmt_small_q)
				code = wpsp_pkg::ST_FMT_SMALL;
			else if (!data_seen_q)
				code = wpsp_pkg::ST_NO_DATA;
			else if (fmt_code_q != wpsp_pkg::FMT_PCM)
				code = wpsp_pkg::ST_NOT_PCM;
			else if (frame_bytes() == 0)
				code = wpsp_pkg::ST_ZERO_FRM;
			else
				code = wpsp_pkg::ST_OK;
			r = '0;
			r.is_status = 1'b1;
			r.status = code;
			r.rate = fmt_rate_q;
			r.channel_count = fmt_ch_q;
			r.sample_bits = fmt_bits_q;
			r.done_res = 1'b1;
			expect_word(r);
			clear_parser();
		end
	endfunction

	// file building
	task automatic add_le(input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++)
			append_byte(8'(v >> (8 * i)));
	endtask

	task automatic add_tag(input logic [31:0] t);
		for (int i = 0; i < 4; i++)
			append_byte(8'(t >> (24 - 8 * i)));
	endtask

	task automatic add_junk(input int n);
		for (int i = 0; i < n; i++)
			append_byte(8'($urandom));
	endtask

	task automatic add_riff(input logic [31:0] riff_t, input logic [31:0] wave_t);
		file_buf.delete();
		add_tag(riff_t);
		add_le($urandom, 4);
		add_tag(wave_t);
	endtask

	task automatic add_chunk(input logic [31:0] t, input int size);
		add_tag(t);
		add_le(size, 4);
		add_junk(size + size % 2);
	endtask

	task automatic add_fmt(input int size, input logic [15:0] code, input logic [15:0] ch,
		input logic [31:0] r, input logic [15:0] bits);
		add_tag(wpsp_pkg::TAG_FMT);
		add_le(size, 4);
		if (size >= wpsp_pkg::FMT_MIN) begin
			add_le(32'(code), 2);
			add_le(32'(ch), 2);
			add_le(r, 4);
			add_junk(6);
			add_le(32'(bits), 2);
			add_junk(size - wpsp_pkg::FMT_MIN);
		end else
			add_junk(size);
		if (size % 2)
			add_junk(1);
	endtask

	task automatic send_word(input logic [7:0] b, input logic fin);
		int gap;
		gap = tx_idle ? $urandom_range(0, 17) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		file_byte = b;
		final_byte = fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		parse_byte(b, fin);
		words_sent++;
	endtask

	task automatic send_file();
		for (int i = 0; i < file_buf.size(); i++)
			send_word(file_buf[i], i == file_buf.size() - 1);
		files_sent++;
	endtask

	task automatic test_pcm_formats();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		// 16-bit mono, full-scale samples
		add_riff(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
		add_fmt(16, wpsp_pkg::FMT_PCM, 16'd1, 32'd0, 16'd16);
		add_tag(wpsp_pkg::TAG_DATA);
		add_le(8, 4);
		add_le(32'h7FFF8000, 4);
		add_le(32'hFFFF0000, 4);
		send_file();
		// 24-bit stereo behind an extra chunk, truncated last frame
		add_riff(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
		add_fmt(18, wpsp_pkg::FMT_PCM, 16'd2, 32'hFFFFFFFF, 16'd24);
		add_chunk(TAG_LIST, 3);
		add_tag(wpsp_pkg::TAG_DATA);
		add_le(20, 4);
		add_le(32'h00800000, 4);
		add_le(32'hFFFFFF00, 4);
		add_le(32'h7FFFFF00, 4);
		add_junk(8);
		send_file();
		// 32-bit mono, odd data size with pad
		add_riff(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
		add_fmt(16, wpsp_pkg::FMT_PCM, 16'd1, $urandom, 16'd32);
		add_chunk(wpsp_pkg::TAG_DATA, 9);
		add_chunk(TAG_LIST, 2);
		send_file();
		// 8-bit width, whose samples come out as zero
		add_riff(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
		add_fmt(16, wpsp_pkg::FMT_PCM, 16'd2, $urandom, 16'd8);
		add_chunk(wpsp_pkg::TAG_DATA, 5);
		send_file();
	endtask

	task automatic test_status_codes();
		// one-byte file and short file
		file_buf.delete();
		append_byte(8'h52);
		send_file();
		add_riff(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
		add_junk(8);
		send_file();
		// bad tags
		add_riff(wpsp_pkg::TAG_RIFF ^ 32'h00000100, wpsp_pkg::TAG_WAVE);
		add_fmt(16, wpsp_pkg::FMT_PCM, 16'd1, $urandom, 16'd16);
		add_chunk(wpsp_pkg::TAG_DATA, 4);
		send_file();
		add_riff(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE ^ 32'h80000000);
		add_fmt(16, wpsp_pkg::FMT_PCM, 16'd1, $urandom, 16'd16);
		add_chunk(wpsp_pkg::TAG_DATA, 4);
		send_file();
		// fmt smaller than its minimum
		add_riff(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
		add_fmt(15, wpsp_pkg::FMT_PCM, 16'd1, $urandom, 16'd16);
		add_chunk(wpsp_pkg::TAG_DATA, 4);
		send_file();
		// no data chunk
		add_riff(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
		add_fmt(16, wpsp_pkg::FMT_PCM, 16'd1, $urandom, 16'd16);
		add_chunk(TAG_LIST, 2);
		send_file();
		// format code not pcm
		add_riff(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
		add_fmt(16, 16'hFFFF, 16'd1, $urandom, 16'd16);
		add_chunk(wpsp_pkg::TAG_DATA, 4);
		send_file();
		// zero frame size
		add_riff(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
		add_fmt(16, wpsp_pkg::FMT_PCM, 16'd0, $urandom, 16'd16);
		add_chunk(wpsp_pkg::TAG_DATA, 4);
		send_file();
		// data before fmt, fmt then skipped
		add_riff(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
		add_chunk(wpsp_pkg::TAG_DATA, 4);
		add_fmt(16, wpsp_pkg::FMT_PCM, 16'd1, $urandom, 16'd16);
		add_chunk(wpsp_pkg::TAG_DATA, 4);
		send_file();
		// second data and late fmt skipped
		add_riff(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
		add_fmt(16, wpsp_pkg::FMT_PCM, 16'd1, $urandom, 16'd16);
		add_chunk(wpsp_pkg::TAG_DATA, 4);
		add_chunk(wpsp_pkg::TAG_DATA, 2);
		add_fmt(16, wpsp_pkg::FMT_PCM, 16'd2, $urandom, 16'd24);
		send_file();
		// zero-length data chunk, then a chunk header cut off at the end
		add_riff(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
		add_fmt(16, wpsp_pkg::FMT_PCM, 16'd1, $urandom, 16'd16);
		add_chunk(wpsp_pkg::TAG_DATA, 0);
		add_chunk(wpsp_pkg::TAG_DATA, 4);
		add_tag(TAG_LIST);
		add_junk(1);
		send_file();
		// oversized data chunk cut off mid-frame
		add_riff(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
		add_fmt(16, wpsp_pkg::FMT_PCM, 16'd1, $urandom, 16'd16);
		add_tag(wpsp_pkg::TAG_DATA);
		add_le(32'hFFFFFFFF, 4);
		add_junk(7);
		send_file();
		// fmt body cut off
		add_riff(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
		add_tag(wpsp_pkg::TAG_FMT);
		add_le(16, 4);
		add_le(32'(wpsp_pkg::FMT_PCM), 2);
		add_le(32'h0000FFFF, 4);
		add_junk(4);
		send_file();
		// widest fmt fields
		add_riff(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
		add_fmt(16, wpsp_pkg::FMT_PCM, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF);
		add_chunk(wpsp_pkg::TAG_DATA, 10);
		send_file();
	endtask

	task automatic test_backpressure();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		rx_hold_req = 200;
		add_riff(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
		add_fmt(16, wpsp_pkg::FMT_PCM, 16'd1, $urandom, 16'd16);
		add_chunk(wpsp_pkg::TAG_DATA, 24);
		send_file();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	task automatic test_random_files();
		int kind, ch, bits, code, fsize, fb, n, idx, done_words;
		done_words = 0;
		while (done_words < RANDOM_WORDS) begin
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			kind = $urandom_range(0, 13);
			if (kind == 0) begin
				file_buf.delete();
				add_junk($urandom_range(1, 60));
			end else begin
				add_riff(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
				if (kind == 1) begin
					idx = $urandom_range(0, 11);
					file_buf[idx] = file_buf[idx] ^ (8'd1 << $urandom_range(0, 7));
				end
				if ($urandom_range(0, 3) == 0)
					add_chunk(TAG_LIST, $urandom_range(0, 5));
				ch = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
				case ($urandom_range(0, 5))
					0, 1: bits = 16;
					2: bits = 24;
					3: bits = 32;
					4: bits = 8;
					default: bits = $urandom_range(0, 40);
				endcase
				code = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : wpsp_pkg::FMT_PCM;
				if (kind == 2)
					fsize = $urandom_range(12, 15);
				else
					fsize = ($urandom_range(0, 3) == 0) ? 18 : 16;
				if (kind == 3)
					add_chunk(wpsp_pkg::TAG_DATA, $urandom_range(0, 8));
				add_fmt(fsize, 16'(code), 16'(ch), $urandom, 16'(bits));
				fb = ch * (bits / 8);
				if (kind != 4)
					add_chunk(wpsp_pkg::TAG_DATA, fb * $urandom_range(0, 6) + $urandom_range(0, 2));
				if (kind == 5) begin
					add_fmt(16, wpsp_pkg::FMT_PCM, 16'd1, $urandom, 16'd16);
					add_chunk(wpsp_pkg::TAG_DATA, $urandom_range(0, 6));
				end
				if ($urandom_range(0, 3) == 0)
					add_chunk(TAG_LIST, $urandom_range(0, 3));
				if (kind == 6) begin
					n = $urandom_range(1, file_buf.size());
					while (file_buf.size() > n)
						void'(file_buf.pop_back());
				end
			end
			done_words += file_buf.size();
			send_file();
		end
	endtask

	// result side: random stalls, long hold on request, compare against parser
	initial begin : result_side
		int hold;
		wpsp_pkg::res_t got, want;
		out_stall = 1'b0;
		forever begin
			if (rx_hold_req > 0) begin
				hold = rx_hold_req;
				rx_hold_req = 0;
			end else
				hold = rx_idle ? $urandom_range(0, 17) : 0;
			repeat (hold) begin
				@(negedge clk);
				out_stall = 1'b1;
			end
			@(negedge clk);
			out_stall = 1'b0;
			@(posedge clk);
			while (out_valid !== 1'b1)
				@(posedge clk);
			got = {is_status, sample, status, rate, channel_count, sample_bits, done_res};
			if (pending_out.size() == 0) begin
				bad_cnt++;
				if (bad_cnt <= 10)
					$display("unexpected: st=%0d smp=%h code=%0d rate=%h ch=%h bits=%h done=%0d",
						got.is_status, got.sample, got.status, got.rate, got.channel_count,
						got.sample_bits, got.done_res);
			end else begin
				want = pending_out.pop_front();
				if (got.is_status !== want.is_status || got.sample !== want.sample ||
					got.status !== want.status || got.rate !== want.rate ||
					got.channel_count !== want.channel_count ||
					got.sample_bits !== want.sample_bits || got.done_res !== want.done_res) begin
					bad_cnt++;
					if (bad_cnt <= 10) begin
						$display("exp: st=%0d smp=%h code=%0d rate=%h ch=%h bits=%h done=%0d",
							want.is_status, want.sample, want.status, want.rate,
							want.channel_count, want.sample_bits, want.done_res);
						$display("got: st=%0d smp=%h code=%0d rate=%h ch=%h bits=%h done=%0d",
							got.is_status, got.sample, got.status, got.rate,
							got.channel_count, got.sample_bits, got.done_res);
					end
				end
				if (want.is_status)
					statuses_checked++;
				else
					samples_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("tb_top: no handshake for %0d cycles, %0d words pending",
				QUIET_LIMIT, pending_out.size());
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		file_byte = '0;
		final_byte = 1'b0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		rx_hold_req = 0;
		bad_cnt = 0;
		files_sent = 0;
		words_sent = 0;
		samples_checked = 0;
		statuses_checked = 0;
		clear_parser();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_pcm_formats();
		test_status_codes();
		test_backpressure();
		test_random_files();

		@(negedge clk);
		in_valid = 1'b0;
		while (pending_out.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (pending_out.size() != 0) begin
			bad_cnt += pending_out.size();
			$display("tb_top: %0d words never arrived", pending_out.size());
		end

		$display("tb_top: %0d files, %0d bytes in; %0d samples and %0d status words checked",
			files_sent, words_sent, samples_checked, statuses_checked);
		$display("tb_top: every status code, 8 to 32 bit frames, skipped and cut chunks, long hold");
		if (bad_cnt == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
